// File: src/lpm_route_table_unit_defines.svh
// Assertion macros for the route table checker.
`ifndef LPM_ROUTE_TABLE_UNIT_DEFINES_SVH
`define LPM_ROUTE_TABLE_UNIT_DEFINES_SVH
// Implication check with a reset disable.
`define LRT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication check with a reset disable.
`define LRT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// File: src/lrt_pkg.sv
// Package: constants, types and helpers shared by the route table.
`timescale 1ns / 1ps
package lrt_pkg;
    localparam int Capacity  = 64;
    localparam int IdxW      = (Capacity > 1) ? $clog2(Capacity) : 1;
    localparam int CntW      = $clog2(Capacity + 1);
    // stored route: dest, prefix, gateway, iface, metric, flags
    localparam int RouteW    = 32 + 6 + 32 + 8 + 32 + 8;

    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_ADD    = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;
    // unassigned op code, answered as a miss
    localparam logic [1:0] OP_NONE   = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_MISS = 2'd2;

    typedef struct packed {
        logic [31:0] dest;
        logic [5:0]  plen;
        logic [31:0] gateway;
        logic [7:0]  iface;
        logic [31:0] metric;
        logic [7:0]  flags;
    } t_route;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] route_address;
        logic [5:0]  pfx_len;
        logic [31:0] gateway_addr;
        logic [7:0]  iface_id;
        logic [31:0] route_metric;
        logic [7:0]  route_flags;
    } t_req;

    typedef struct packed {
        logic [1:0] status;
        t_route     hit;
    } t_rsp;

    function automatic logic [31:0] mask_of(input logic [5:0] len);
        logic [31:0] m;
        m = '1;
        if (len == 6'd0) m = '0;
        else if (len < 6'd32) m = ~(32'hFFFF_FFFF >> len[4:0]);
        return m;
    endfunction
endpackage

// File: src/lrt_if.sv
// Valid/ready channel interfaces for requests and responses.
`timescale 1ns / 1ps
interface lrt_req_if import lrt_pkg::*; ();
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface lrt_rsp_if import lrt_pkg::*; ();
    logic valid;
    logic ready;
    t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: src/lpm_route_table_unit.sv
// Top level of the longest-prefix-match route table.
//
//  channel   dir  handshake      payload
//  i_req     in   valid/ready    op, address, prefix, gateway, iface, metric, flags
//  o_rsp     out  valid/ready    status and chosen route
//  cfg       in   i_cfg_we       up_flag_mask
//
// Add, unknown op, or lookup/remove on an empty table: the response is valid in
// the cycle after the item is taken. Lookup: one memory read per entry in S_SCAN,
// then a result state S_OUT. Remove: a hit stops the scan, then S_MOVE
// reads the last entry and writes it into the freed slot.
// Reset empties the table at once; a new item waits until the response is taken.
`timescale 1ns / 1ps
module lpm_route_table_unit import lrt_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    lrt_req_if.sink    i_req,
    lrt_rsp_if.source  o_rsp
);
    logic [7:0]      r_up_mask;
    logic            we;
    logic [IdxW-1:0] waddr, raddr;
    t_route          wdata, rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_up_mask <= 8'd1;
        else if (i_cfg_we) r_up_mask <= i_cfg_wdata;
    end

    lrt_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_up_mask(r_up_mask), .req(i_req), .rsp(o_rsp),
        .o_we(we), .o_waddr(waddr), .o_wdata(wdata), .o_raddr(raddr), .i_rdata(rdata)
    );

    lrt_ram #(.Width(RouteW), .Depth(Capacity)) u_ram (
        .i_clk, .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );
endmodule

// File: src/lrt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
`timescale 1ns / 1ps
module lrt_ram #(
    parameter int Width = 8,
    parameter int Depth = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// File: src/lrt_ctrl.sv
// Sequencer: add, remove scan with last-entry move, and lookup scan.
`timescale 1ns / 1ps
module lrt_ctrl import lrt_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [7:0]      i_up_mask,
    lrt_req_if.sink         req,
    lrt_rsp_if.source       rsp,
    output logic            o_we,
    output logic [IdxW-1:0] o_waddr,
    output t_route          o_wdata,
    output logic [IdxW-1:0] o_raddr,
    input  t_route          i_rdata
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_MOVE = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]      r_state, n_state;
    logic [CntW-1:0] r_count, n_count;
    logic [CntW-1:0] r_idx, n_idx;     // address issued last cycle
    t_req            r_req, n_req;
    logic            r_found, n_found;
    t_route          r_best, n_best;
    logic [IdxW-1:0] r_hole, n_hole;
    t_rsp            r_rsp, n_rsp;
    logic            r_rsp_vld, n_rsp_vld;

    logic [31:0] md;
    logic        is_up, is_match, better, rem_hit;

    assign md       = r_req.route_address & mask_of(r_req.pfx_len);
    assign is_up    = (i_rdata.flags & i_up_mask) == i_up_mask;
    assign is_match = (r_req.route_address & mask_of(i_rdata.plen)) == i_rdata.dest;
    assign better   = !r_found || (i_rdata.plen > r_best.plen) ||
                      (i_rdata.plen == r_best.plen && i_rdata.metric < r_best.metric);
    assign rem_hit  = i_rdata.dest == md && i_rdata.plen == r_req.pfx_len;

    assign req.ready = (r_state == S_IDLE) && !r_rsp_vld;
    assign rsp.valid = r_rsp_vld;
    assign rsp.data  = r_rsp;

    always_comb begin
        n_state = r_state; n_count = r_count; n_idx = r_idx;
        n_req = r_req; n_found = r_found; n_best = r_best; n_hole = r_hole;
        n_rsp = r_rsp; n_rsp_vld = r_rsp_vld;
        o_we = 1'b0; o_waddr = r_hole; o_wdata = i_rdata;
        o_raddr = r_idx[IdxW-1:0];
        if (rsp.valid && rsp.ready) n_rsp_vld = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (req.valid && req.ready) begin
                    n_req = req.data; n_found = 1'b0; n_rsp = '0;
                    unique case (req.data.op)
                        OP_ADD: begin
                            if (r_count == CntW'(Capacity)) begin
                                n_rsp.status = ST_FULL;
                            end else begin
                                o_we    = 1'b1;
                                o_waddr = r_count[IdxW-1:0];
                                o_wdata = '{dest: req.data.route_address &
                                                  mask_of(req.data.pfx_len),
                                            plen: req.data.pfx_len,
                                            gateway: req.data.gateway_addr,
                                            iface: req.data.iface_id,
                                            metric: req.data.route_metric,
                                            flags: req.data.route_flags};
                                n_count = r_count + 1'b1;
                                n_rsp.status = ST_OK;
                            end
                            n_rsp_vld = 1'b1;
                        end
                        OP_LOOKUP, OP_REMOVE: begin
                            if (r_count == '0) begin
                                n_rsp.status = ST_MISS;
                                n_rsp_vld = 1'b1;
                            end else begin
                                o_raddr = '0; n_idx = '0;
                                n_state = S_SCAN;
                            end
                        end
                        default: begin
                            n_rsp.status = ST_MISS;
                            n_rsp_vld = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // r_idx holds the index of the data now on i_rdata
                if (r_req.op == OP_REMOVE && rem_hit) begin
                    n_hole = r_idx[IdxW-1:0];
                    n_idx = r_count - 1'b1;
                    o_raddr = n_idx[IdxW-1:0];
                    n_state = S_MOVE;
                end else begin
                    if (r_req.op == OP_LOOKUP && is_up && is_match && better) begin
                        n_found = 1'b1; n_best = i_rdata;
                    end
                    if (r_idx + 1'b1 == r_count) begin
                        n_state = S_OUT;
                    end else begin
                        n_idx = r_idx + 1'b1;
                        o_raddr = n_idx[IdxW-1:0];
                    end
                end
            end
            S_MOVE: begin
                o_we = 1'b1;
                n_count = r_count - 1'b1;
                n_rsp = '0; n_rsp.status = ST_OK; n_rsp_vld = 1'b1;
                n_state = S_IDLE;
            end
            S_OUT: begin
                n_rsp = '0;
                if (r_req.op == OP_LOOKUP && r_found) begin
                    n_rsp.status = ST_OK; n_rsp.hit = r_best;
                end else begin
                    n_rsp.status = ST_MISS;
                end
                n_rsp_vld = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_count <= '0; r_rsp_vld <= 1'b0;
        end else begin
            r_state <= n_state; r_count <= n_count; r_rsp_vld <= n_rsp_vld;
        end
        r_idx <= n_idx; r_req <= n_req; r_found <= n_found; r_best <= n_best;
        r_hole <= n_hole; r_rsp <= n_rsp;
    end
endmodule

// File: src/lrt_checker.sv
// Port-level checker for the route table, bound to the top level.
`timescale 1ns / 1ps
`include "lpm_route_table_unit_defines.svh"
module lrt_checker import lrt_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input t_rsp i_out_data
);
    `LRT_ASSERT_IMPL(a_one_item, i_clk, i_rst_n, i_out_valid, !i_in_ready, "input taken while response pending")
    `LRT_ASSERT_IMPL(a_miss_zero, i_clk, i_rst_n, i_out_valid && i_out_data.status != ST_OK, i_out_data.hit == '0, "payload not zero on miss")
    `LRT_ASSERT_IMPL(a_status, i_clk, i_rst_n, i_out_valid, i_out_data.status <= ST_MISS, "bad status code")
    `LRT_ASSERT_NEXT(a_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_data), "response dropped")
endmodule

bind lpm_route_table_unit lrt_checker u_lrt_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_req.valid), .i_in_ready(i_req.ready),
    .i_out_valid(o_rsp.valid), .i_out_ready(o_rsp.ready), .i_out_data(o_rsp.data)
);

// File: tb/sv/tb_top.sv
// Testbench for the route table: random and directed ops against a local table model.
`timescale 1ns / 1ps
module tb_top;
    import lrt_pkg::*;

    class route_scoreboard;
        t_route      routes[$];
        logic [7:0]  up_mask;
        t_rsp        pending[$];
        int          errors;

        function new();
            up_mask = 8'd1;
            errors  = 0;
        endfunction

        function logic [31:0] prefix_mask(logic [5:0] len);
            if (len == 0) return 32'h0;
            if (len >= 32) return 32'hFFFF_FFFF;
            return 32'hFFFF_FFFF << (32 - len);
        endfunction

        // predict the response of one accepted request
        function void note_request(t_req r);
            t_rsp        rsp;
            logic [31:0] md;
            int          best;
            int          k;
            rsp  = '0;
            best = -1;
            if (r.op == OP_ADD) begin
                if (routes.size() >= Capacity) begin
                    rsp.status = ST_FULL;
                end else begin
                    t_route e;
                    e.dest    = r.route_address & prefix_mask(r.pfx_len);
                    e.plen    = r.pfx_len;
                    e.gateway = r.gateway_addr;
                    e.iface   = r.iface_id;
                    e.metric  = r.route_metric;
                    e.flags   = r.route_flags;
                    routes.push_back(e);
                    rsp.status = ST_OK;
                end
            end else if (r.op == OP_REMOVE) begin
                md = r.route_address & prefix_mask(r.pfx_len);
                rsp.status = ST_MISS;
                for (k = 0; k < routes.size(); k++) begin
                    if (routes[k].dest == md && routes[k].plen == r.pfx_len) begin
                        routes[k] = routes[routes.size() - 1];
                        void'(routes.pop_back());
                        rsp.status = ST_OK;
                        break;
                    end
                end
            end else if (r.op == OP_LOOKUP) begin
                for (k = 0; k < routes.size(); k++) begin
                    if ((routes[k].flags & up_mask) != up_mask) continue;
                    if ((r.route_address & prefix_mask(routes[k].plen)) != routes[k].dest)
                        continue;
                    if (best < 0 || routes[k].plen > routes[best].plen ||
                        (routes[k].plen == routes[best].plen &&
                         routes[k].metric < routes[best].metric))
                        best = k;
                end
                if (best < 0) rsp.status = ST_MISS;
                else begin
                    rsp.status = ST_OK;
                    rsp.hit    = routes[best];
                end
            end else begin
                rsp.status = ST_MISS;
            end
            pending.push_back(rsp);
        endfunction

        function void check_response(t_rsp got);
            t_rsp want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected response %h", $realtime, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.status !== want.status) begin
                $display("%0t: status exp %0d got %0d", $realtime, want.status, got.status);
                errors++;
            end
            if (got.hit.dest !== want.hit.dest) begin
                $display("%0t: dest exp %h got %h", $realtime, want.hit.dest, got.hit.dest);
                errors++;
            end
            if (got.hit.plen !== want.hit.plen) begin
                $display("%0t: plen exp %0d got %0d", $realtime, want.hit.plen, got.hit.plen);
                errors++;
            end
            if (got.hit.gateway !== want.hit.gateway) begin
                $display("%0t: gateway exp %h got %h", $realtime, want.hit.gateway,
                         got.hit.gateway);
                errors++;
            end
            if (got.hit.iface !== want.hit.iface) begin
                $display("%0t: iface exp %h got %h", $realtime, want.hit.iface, got.hit.iface);
                errors++;
            end
            if (got.hit.metric !== want.hit.metric) begin
                $display("%0t: metric exp %h got %h", $realtime, want.hit.metric,
                         got.hit.metric);
                errors++;
            end
            if (got.hit.flags !== want.hit.flags) begin
                $display("%0t: flags exp %h got %h", $realtime, want.hit.flags, got.hit.flags);
                errors++;
            end
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic [7:0] i_cfg_wdata = 8'd0;

    lrt_req_if req_ch ();
    lrt_rsp_if rsp_ch ();

    lpm_route_table_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_ch.sink),
        .o_rsp       (rsp_ch.source)
    );

    always #5 i_clk = ~i_clk;

    route_scoreboard sb = new();
    bit              idle_on = 1'b1;
    int              hold_cycles = 0;

    initial begin
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        rsp_ch.ready = 1'b0;
    end

    // response side: random stalls and an occasional long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) sb.check_response(rsp_ch.data);
            if (hold_cycles > 0) begin
                hold_cycles  = hold_cycles - 1;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= !(idle_on && $urandom_range(99) < 30);
            end
        end
    end

    // stored routes reused so removes and lookups hit
    logic [31:0] known_addr[$];
    logic [5:0]  known_len[$];

    function automatic t_req rand_req(int lean);
        t_req r;
        int   pick;
        r.op            = 2'($urandom_range(2));
        r.route_address = $urandom();
        r.pfx_len       = 6'($urandom_range(32));
        if ($urandom_range(19) == 0) r.pfx_len = 6'($urandom_range(63));
        if ($urandom_range(49) == 0) r.op = OP_NONE;
        r.gateway_addr  = $urandom();
        r.iface_id      = 8'($urandom());
        r.route_metric  = ($urandom_range(1)) ? $urandom() : 32'($urandom_range(3));
        r.route_flags   = 8'($urandom());
        if (lean > 0 && r.op == OP_ADD) r.op = OP_REMOVE;
        if (lean < 0 && r.op == OP_REMOVE) r.op = OP_ADD;
        if (known_addr.size() > 0 && $urandom_range(99) < 70) begin
            pick = $urandom_range(known_addr.size() - 1);
            if (r.op == OP_REMOVE || r.op == OP_ADD) begin
                r.route_address = known_addr[pick] |
                                  ($urandom() & ~sb.prefix_mask(known_len[pick]));
                r.pfx_len       = known_len[pick];
            end else begin
                r.route_address = known_addr[pick] |
                                  ($urandom() & ~sb.prefix_mask(known_len[pick]));
            end
        end
        if (r.op == OP_ADD) begin
            known_addr.push_back(r.route_address);
            known_len.push_back(r.pfx_len);
            if (known_addr.size() > 40) begin
                void'(known_addr.pop_front());
                void'(known_len.pop_front());
            end
        end
        return r;
    endfunction

    // valid stays high after an accepted item until the next item or an idle cycle
    task automatic send_req(t_req r);
        while (idle_on && $urandom_range(99) < 30) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= r;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        sb.note_request(r);
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        while (sb.pending.size() > 0) @(posedge i_clk);
        repeat (Capacity + 8) @(posedge i_clk);
    endtask

    task automatic write_mask(logic [7:0] m);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= m;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.up_mask = m;
    endtask

    function automatic t_req mk(logic [1:0] op, logic [31:0] a, logic [5:0] l,
                                logic [31:0] m, logic [7:0] f);
        t_req r;
        r.op = op; r.route_address = a; r.pfx_len = l;
        r.gateway_addr = $urandom(); r.iface_id = 8'($urandom());
        r.route_metric = m; r.route_flags = f;
        return r;
    endfunction

    initial begin
        int   n;
        int   lean;
        int   phase;
        t_req r;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty lookup, prefix extremes, ties, remove, unknown op
        send_req(mk(OP_LOOKUP, 32'h0A00_0001, 6'd0, 32'd0, 8'h01));
        send_req(mk(OP_ADD, 32'hFFFF_FFFF, 6'd0, 32'hFFFF_FFFF, 8'hFF));
        send_req(mk(OP_ADD, 32'h0A01_0203, 6'd8, 32'd5, 8'h01));
        send_req(mk(OP_ADD, 32'h0A01_0203, 6'd8, 32'd3, 8'h01));
        send_req(mk(OP_ADD, 32'h0A01_0203, 6'd8, 32'd3, 8'h01));
        send_req(mk(OP_ADD, 32'h0A01_0203, 6'd32, 32'd9, 8'h00));
        send_req(mk(OP_ADD, 32'h0A01_0203, 6'd33, 32'd9, 8'h03));
        send_req(mk(OP_ADD, 32'h0A01_0203, 6'd63, 32'd0, 8'h01));
        send_req(mk(OP_LOOKUP, 32'h0A01_0203, 6'd0, 32'd0, 8'h00));
        send_req(mk(OP_LOOKUP, 32'h0AFF_0000, 6'd0, 32'd0, 8'h00));
        send_req(mk(OP_LOOKUP, 32'h0000_0000, 6'd0, 32'd0, 8'h00));
        send_req(mk(OP_REMOVE, 32'h0A99_9999, 6'd8, 32'd0, 8'h00));
        send_req(mk(OP_REMOVE, 32'h0A01_0203, 6'd31, 32'd0, 8'h00));
        send_req(mk(OP_LOOKUP, 32'h0A01_0203, 6'd0, 32'd0, 8'h00));
        send_req(mk(OP_NONE, 32'hFFFF_FFFF, 6'h3F, 32'hFFFF_FFFF, 8'hFF));
        drain();
        write_mask(8'h00);
        send_req(mk(OP_LOOKUP, 32'h0A01_0203, 6'd0, 32'd0, 8'h00));
        drain();
        write_mask(8'hFF);
        send_req(mk(OP_LOOKUP, 32'h0A01_0203, 6'd0, 32'd0, 8'h00));
        drain();
        write_mask(8'h03);
        send_req(mk(OP_LOOKUP, 32'h0A01_0203, 6'd0, 32'd0, 8'h00));

        // random phases; table is grown to full and shrunk in turn
        for (phase = 0; phase < 6; phase++) begin
            drain();
            case (phase)
                0: write_mask(8'h01);
                1: write_mask(8'($urandom_range(1, 255)));
                2: write_mask(8'h80);
                3: write_mask(8'hFF);
                4: write_mask(8'h00);
                default: write_mask(8'h01);
            endcase
            idle_on = (phase != 2);
            if (phase == 1) hold_cycles = 300;
            for (n = 0; n < 170; n++) begin
                lean = (phase % 2 == 0) ? -1 : ((n > 100) ? 1 : 0);
                if (phase == 3 && n == 80) drain();
                r = rand_req(lean);
                if (r.route_flags[0] == 1'b0 && $urandom_range(1)) r.route_flags[0] = 1'b1;
                send_req(r);
            end
        end
        idle_on = 1'b1;
        drain();
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("== FAIL ==");
        $finish;
    end
endmodule

// File: lpm_route_table_unit.f
+incdir+src
src/lrt_pkg.sv
src/lrt_if.sv
src/lrt_ram.sv
src/lrt_ctrl.sv
src/lpm_route_table_unit.sv
src/lrt_checker.sv
tb/sv/tb_top.sv
